@@ design/tcw_pkg.sv @@
package tcw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned SCROLL_N   = CELL_COUNT - COLUMNS;

  // derived widths
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);

  // fixed field widths
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned TGT_W  = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned OFF_W  = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h2a;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // command codes
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUT     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_NEWLINE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MOVE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCROLL,
    ST_FIN
  } state_e;

endpackage

@@ design/text_console_writer_top.sv @@
// put char, new line, move to and read cell without scroll go straight to ST_FIN,
// where the result is registered; a scroll copies one cell per cycle (read port
// ahead, write port behind), then blanks the last row; clear blanks every cell
// one item at a time: input stalls until the result is registered
// reset: asynchronous, active low; afterwards a clearing pass writes spaces into
// all CELL_COUNT (2000) cells of the screen memory while input is stalled
module text_console_writer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::FUNC_W-1:0]   func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   ch_i,
  input  logic [tcw_pkg::TGT_W-1:0]    col_i,
  input  logic [tcw_pkg::TGT_W-1:0]    row_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::OFF_W-1:0]    cursor_offset_o,
  output logic                         status_o,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_attr_o
);
  import tcw_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              busy_q, busy_d;
  logic              status_q, status_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CHAR_W-1:0] attr_q;

  logic              out_valid_q, out_valid_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              ostat_q, ostat_d;
  logic [CHAR_W-1:0] ochar_q, ochar_d;
  logic [CHAR_W-1:0] oattr_q, oattr_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CHAR_W-1:0] mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [CHAR_W-1:0] rdata_q;
  logic [CHAR_W-1:0] screen_mem [CELL_COUNT];

  logic              accept;
  logic [ADDR_W-1:0] cur_pos;
  logic              out_free;

  // screen memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= screen_mem[mem_ra];
    end
  end

  // color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_pos    = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      busy_q      <= 1'b0;
      status_q    <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      busy_q      <= busy_d;
      status_q    <= status_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    ostat_q <= ostat_d;
    ochar_q <= ochar_d;
    oattr_q <= oattr_d;
  end

  // next state, memory control and result load
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    busy_d      = busy_q;
    status_d    = status_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q;
    off_d       = off_q;
    ostat_d     = ostat_q;
    ochar_d     = ochar_q;
    oattr_d     = oattr_q;
    mem_we      = 1'b0;
    mem_wa      = cnt_q;
    mem_wd      = BLANK_CHAR;
    mem_re      = 1'b0;
    mem_ra      = ADDR_W'(32'(cnt_q) + COLUMNS);

    // output transfer drains the slot
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = 1'b0;
          rd_ok_d  = 1'b0;
          busy_d   = 1'b1;
          state_d  = ST_FIN;
          case (func_i) inside
            FN_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              cnt_d   = '0;
              state_d = ST_FILL;
            end
            FN_PUT, FN_NEWLINE: begin
              if (func_i == FN_PUT) begin
                mem_we = 1'b1;
                mem_wa = cur_pos;
                mem_wd = ch_i;
              end
              if (func_i == FN_PUT && col_q != COL_LAST) begin
                col_d = col_q + 1'b1;
              end else begin
                col_d = '0;
                if (row_q == ROW_LAST) begin
                  cnt_d   = '0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
            end
            FN_MOVE: begin
              if (32'(col_i) >= COLUMNS || 32'(row_i) >= ROWS) begin
                status_d = 1'b1;
              end else begin
                col_d = COL_W'(col_i);
                row_d = ROW_W'(row_i);
              end
            end
            FN_READ: begin
              if (32'(cell_index_i) < CELL_COUNT) begin
                rd_ok_d = 1'b1;
                mem_re  = 1'b1;
                mem_ra  = ADDR_W'(cell_index_i);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // copy one cell up a row per cycle: read ahead, write the previous read
      ST_SCROLL: begin
        if (cnt_q != '0) begin
          mem_we = 1'b1;
          mem_wa = cnt_q - 1'b1;
          mem_wd = rdata_q;
        end
        if (32'(cnt_q) == SCROLL_N) begin
          state_d = ST_FILL;
        end else begin
          mem_re = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end

      // blank from cnt to the end of the store
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_q;
        mem_wd = BLANK_CHAR;
        if (32'(cnt_q) == CELL_COUNT - 1) begin
          state_d = busy_q ? ST_FIN : ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          off_d       = OFF_W'(32'(row_q) * COLUMNS + 32'(col_q));
          ostat_d     = status_q;
          ochar_d     = rd_ok_q ? rdata_q : '0;
          oattr_d     = attr_q;
          busy_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_offset_o = off_q;
  assign status_o        = ostat_q;
  assign cell_char_o     = ochar_q;
  assign cell_attr_o     = oattr_q;

endmodule

@@ design/tcw_checker.sv @@
module tcw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [tcw_pkg::OFF_W-1:0]    cursor_offset_o,
  input logic                         status_o,
  input logic [tcw_pkg::CHAR_W-1:0]   cell_char_o
);
  import tcw_pkg::*;

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a new result only appears after the block was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work");

  // cursor stays on the screen, a failed move carries no character
  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_offset_o) < CELL_COUNT) && !(status_o && cell_char_o != '0))
    else $error("result fields inconsistent");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(cursor_offset_o))
    else $error("stalled result changed");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cursor_offset_o (cursor_offset_o),
  .status_o        (status_o),
  .cell_char_o     (cell_char_o)
);

@@ test/text_console_writer_tb.sv @@
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RESET_CYCLES = 7;
  localparam logic [IDX_W-1:0] IDX_TOP = '1;

  // status codes of a result
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // command codes the block leaves undecoded
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [TGT_W-1:0]  col;
    logic [TGT_W-1:0]  row;
    logic [IDX_W-1:0]  idx;
  } console_cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic              status;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } console_result_t;

  typedef struct packed {
    console_cmd_t    cmd;
    logic            typed;
    console_result_t want;
  } directed_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CHAR_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [CHAR_W-1:0]   ch_i;
  logic [TGT_W-1:0]    col_i;
  logic [TGT_W-1:0]    row_i;
  logic [IDX_W-1:0]    cell_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OFF_W-1:0]    cursor_offset_o;
  logic                status_o;
  logic [CHAR_W-1:0]   cell_char_o;
  logic [CHAR_W-1:0]   cell_attr_o;

  text_console_writer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .ch_i            (ch_i),
    .col_i           (col_i),
    .row_i           (row_i),
    .cell_index_i    (cell_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_offset_o (cursor_offset_o),
    .status_o        (status_o),
    .cell_char_o     (cell_char_o),
    .cell_attr_o     (cell_attr_o)
  );

  // shadow copy of the screen, cursor and color register
  logic [CHAR_W-1:0] screen_model [CELL_COUNT];
  logic [COL_W-1:0]  model_col;
  logic [ROW_W-1:0]  model_row;
  logic [CHAR_W-1:0] model_attr;

  console_result_t pending_results [$];
  console_result_t seen_want;
  directed_row_t   directed_rows [$];

  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned result_count;
  int unsigned error_count;
  int unsigned scroll_count;
  int unsigned clear_count;
  int unsigned color_writes;
  int unsigned send_idle;
  int unsigned recv_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void model_clear();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CHAR;
    model_col = '0;
    model_row = '0;
  endfunction

  // next line, scrolling the screen up when leaving the bottom row
  function automatic void model_next_line();
    model_col = '0;
    if (model_row == ROW_LAST) begin
      for (int i = 0; i < SCROLL_N; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = SCROLL_N; i < CELL_COUNT; i++) screen_model[i] = BLANK_CHAR;
      scroll_count++;
    end else begin
      model_row++;
    end
  endfunction

  function automatic console_result_t predict_console(input console_cmd_t c);
    console_result_t r;
    int pos;
    r.status    = ST_OK;
    r.cell_char = '0;
    case (c.func)
      FN_CLEAR: begin
        model_clear();
        clear_count++;
      end
      FN_PUT: begin
        pos = int'(model_row) * COLUMNS + int'(model_col);
        screen_model[pos] = c.ch;
        if (model_col == COL_LAST) model_next_line();
        else model_col++;
      end
      FN_NEWLINE: model_next_line();
      FN_MOVE: begin
        if (c.col >= COLUMNS || c.row >= ROWS) begin
          r.status = ST_RANGE;
        end else begin
          model_col = COL_W'(c.col);
          model_row = ROW_W'(c.row);
        end
      end
      FN_READ: begin
        if (c.idx < CELL_COUNT) r.cell_char = screen_model[c.idx];
      end
      default: ;
    endcase
    r.offset    = OFF_W'(int'(model_row) * COLUMNS + int'(model_col));
    r.cell_attr = model_attr;
    return r;
  endfunction

  function automatic directed_row_t dir_row(input logic [FUNC_W-1:0] f,
                                            input logic [CHAR_W-1:0] ch,
                                            input logic [TGT_W-1:0] col,
                                            input logic [TGT_W-1:0] row,
                                            input logic [IDX_W-1:0] idx,
                                            input logic typed,
                                            input logic [OFF_W-1:0] off,
                                            input logic st,
                                            input logic [CHAR_W-1:0] chr);
    directed_row_t d;
    d.cmd   = '{func: f, ch: ch, col: col, row: row, idx: idx};
    d.typed = typed;
    d.want  = '{offset: off, status: st, cell_char: chr, cell_attr: ATTR_RESET};
    return d;
  endfunction

  // random command, biased toward the bottom rows so scrolls happen often
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    c.func = FN_READ;
    c.ch   = CHAR_W'($urandom);
    c.col  = TGT_W'($urandom);
    c.row  = TGT_W'($urandom);
    c.idx  = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 2) begin
      c.func = FN_CLEAR;
    end else if (pick < 42) begin
      c.func = FN_PUT;
    end else if (pick < 50) begin
      c.func = FN_NEWLINE;
    end else if (pick < 66) begin
      c.func = FN_MOVE;
      case ($urandom_range(3))
        0: c.col = TGT_W'($urandom_range(255, COLUMNS));
        1: c.row = TGT_W'($urandom_range(255, ROWS));
        default: begin
          c.col = TGT_W'($urandom_range(COLUMNS - 1));
          if ($urandom_range(1)) c.row = TGT_W'($urandom_range(ROWS - 1));
          else c.row = TGT_W'($urandom_range(ROWS - 1, ROWS - 5));
        end
      endcase
    end else if (pick < 93) begin
      c.func = FN_READ;
      case ($urandom_range(9))
        0: c.idx = IDX_W'($urandom_range(IDX_TOP, CELL_COUNT));
        1, 2, 3, 4: c.idx = IDX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 4 * COLUMNS));
        default: c.idx = IDX_W'($urandom_range(CELL_COUNT - 1));
      endcase
    end else begin
      c.func = FUNC_W'($urandom_range(FN_SPARE_C, FN_SPARE_A));
    end
    return c;
  endfunction

  // drive one command transfer, then log what it should produce
  task automatic send_cmd(input console_cmd_t c, input logic typed,
                          input console_result_t want);
    console_result_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= c.func;
    ch_i         <= c.ch;
    col_i        <= c.col;
    row_i        <= c.row;
    cell_index_i <= c.idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_console(c);
    pending_results.push_back(typed ? want : pred);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_color(input logic [CHAR_W-1:0] value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_attr = value;
    color_writes++;
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no command pending",
                                  result_count));
      end else begin
        seen_want = pending_results.pop_front();
        if (cursor_offset_o !== seen_want.offset)
          report_mismatch($sformatf("result %0d cursor_offset got %0d want %0d",
                                    result_count, cursor_offset_o, seen_want.offset));
        if (status_o !== seen_want.status)
          report_mismatch($sformatf("result %0d status got %0b want %0b",
                                    result_count, status_o, seen_want.status));
        if (cell_char_o !== seen_want.cell_char)
          report_mismatch($sformatf("result %0d cell_char got %h want %h",
                                    result_count, cell_char_o, seen_want.cell_char));
        if (cell_attr_o !== seen_want.cell_attr)
          report_mismatch($sformatf("result %0d cell_attr got %h want %h",
                                    result_count, cell_attr_o, seen_want.cell_attr));
      end
      result_count++;
    end
  end

  // stimulus
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = FN_READ;
    ch_i         = '0;
    col_i        = '0;
    row_i        = '0;
    cell_index_i = '0;
    out_stall_i  = 1'b0;
    send_idle    = 27;
    recv_idle    = 60;
    model_clear();
    model_attr = ATTR_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, range limits, wrap and scroll, spare codes
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 0, 1, 0, ST_OK, BLANK_CHAR));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 1999, 1, 0, ST_OK, BLANK_CHAR));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, IDX_TOP, 1, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 79, 24, 0, 1, 1999, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 80, 0, 0, 1, 1999, ST_RANGE, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 0, 25, 0, 1, 1999, ST_RANGE, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 255, 255, 0, 1, 1999, ST_RANGE, 0));
    directed_rows.push_back(dir_row(FN_PUT, 8'hFF, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 1919, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 1999, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 0, 0, 0, 1, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_PUT, 8'h00, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_PUT, 8'h41, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_NEWLINE, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_SPARE_A, 8'hFF, 8'hFF, 8'hFF, IDX_TOP, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_SPARE_C, 8'hFF, 8'hFF, 8'hFF, IDX_TOP, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_SPARE_B, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 79, 3, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_PUT, 8'h7E, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 319, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_MOVE, 0, 0, 24, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_NEWLINE, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_CLEAR, 8'h55, 8'hAA, 8'h55, 11'h2AA, 1, 0, ST_OK, 0));
    directed_rows.push_back(dir_row(FN_READ, 0, 0, 0, 1919, 1, 0, ST_OK, BLANK_CHAR));
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // random, slow receiver
    set_color(8'hFF);
    repeat (170) send_cmd(random_cmd(), 1'b0, '0);

    // random, slow sender
    send_idle = 60;
    recv_idle = 27;
    set_color(8'h00);
    repeat (170) send_cmd(random_cmd(), 1'b0, '0);

    // random, full rate
    send_idle = 0;
    recv_idle = 0;
    set_color(CHAR_W'($urandom_range(255)));
    repeat (160) send_cmd(random_cmd(), 1'b0, '0);

    wait_drained();
    $display("checked %0d results against %0d command transfers", result_count, sent_count);
    $display("run saw %0d scrolls, %0d clears, %0d color settings, %0d mismatches",
             scroll_count, clear_count, color_writes, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
